[design/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  // Fixed widths of the channel payload fields.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int HASH_W   = 32;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 10;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED   = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

endpackage

[design/chm_in_if.sv]
// ----------------------------------------------------------------------------
// chm_in_if
// Request channel: operation, key, value and hash with valid/ready.
// ----------------------------------------------------------------------------
interface chm_in_if;
  logic                        valid;
  logic                        ready;
  logic [chm_pkg::OP_W-1:0]    op;
  logic [chm_pkg::KEY_W-1:0]   key;
  logic [chm_pkg::VALUE_W-1:0] value;
  logic [chm_pkg::HASH_W-1:0]  hash_value;

  modport source (output valid, op, key, value, hash_value, input ready);
  modport sink   (input valid, op, key, value, hash_value, output ready);
endinterface

[design/chm_out_if.sv]
// ----------------------------------------------------------------------------
// chm_out_if
// Result channel: status, returned value and occupancy with valid/ready.
// ----------------------------------------------------------------------------
interface chm_out_if;
  logic                         valid;
  logic                         ready;
  logic [chm_pkg::STATUS_W-1:0] status;
  logic [chm_pkg::VALUE_W-1:0]  value_out;
  logic [chm_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, status, value_out, occupancy, input ready);
  modport sink   (input valid, status, value_out, occupancy, output ready);
endinterface

[design/chm_ram.sv]
// ----------------------------------------------------------------------------
// chm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/chm_queue.sv]
// ----------------------------------------------------------------------------
// chm_queue
// Two-entry queue between the request front end and the table engine.
// ----------------------------------------------------------------------------
module chm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);
  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;

  assign not_full  = (fill_r != 2'd2);
  assign not_empty = (fill_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end
endmodule

[design/chm_front.sv]
// ----------------------------------------------------------------------------
// chm_front
// Accepts requests, reduces the hash to a bucket index and queues them.
// ----------------------------------------------------------------------------
module chm_front #(
  parameter int BUCKETS    = 256,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic enable,
  chm_in_if.sink in_ch,
  input  logic q_not_full,
  output logic q_push,
  output logic [chm_pkg::OP_W+KEY_BITS+VALUE_BITS+$clog2(BUCKETS)-1:0] q_data
);
  import chm_pkg::*;

  localparam int  BW   = $clog2(BUCKETS);
  localparam bit  POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] val_in;

  assign key_in = KEY_BITS'(in_ch.key);
  assign val_in = VALUE_BITS'(in_ch.value);

  generate
    if (POW2) begin : g_mask
      // The bucket is simply the low hash bits.
      assign in_ch.ready = enable && q_not_full;
      assign q_push      = in_ch.valid && in_ch.ready;
      assign q_data      = {in_ch.op, key_in, val_in, in_ch.hash_value[BW-1:0]};
    end else begin : g_reduce
      // Remainder by a constant through a scaled reciprocal. The quotient
      // estimate is exact or one short, so one compare and subtract finishes.
      // The 33-bit reciprocal is multiplied in two halves, low half first.
      localparam logic [32:0]       RECIP    =
        33'((64'd1 << (HASH_W + BW)) / 64'(BUCKETS));
      localparam logic [16:0]       RECIP_LO = RECIP[16:0];
      localparam logic [15:0]       RECIP_HI = RECIP[32:17];
      localparam logic [BW-1:0]     MOD      = BW'(BUCKETS);
      localparam logic [HASH_W-1:0] MOD_W    = HASH_W'(BUCKETS);

      logic                  busy_r;
      logic [1:0]            phase_r;
      logic [HASH_W-1:0]     hash_r;
      logic [HASH_W+32:0]    prod_r;
      logic [HASH_W-1:0]     diff_r;
      logic [OP_W-1:0]       op_r;
      logic [KEY_BITS-1:0]   key_r;
      logic [VALUE_BITS-1:0] val_r;
      logic [HASH_W+16:0]    mul_lo;
      logic [HASH_W+15:0]    mul_hi;
      logic [32-BW:0]        quot;
      logic [HASH_W:0]       mul_q;
      logic [BW-1:0]         bkt;
      logic                  reducing;

      assign mul_lo      = hash_r * RECIP_LO;
      assign mul_hi      = hash_r * RECIP_HI;
      assign quot        = prod_r[HASH_W+32:HASH_W+BW];
      assign mul_q       = quot * MOD;
      assign bkt         = (diff_r >= MOD_W) ? BW'(diff_r - MOD_W) : diff_r[BW-1:0];
      assign reducing    = busy_r && (phase_r != 2'd3);
      assign in_ch.ready = enable && !busy_r;
      assign q_push      = busy_r && (phase_r == 2'd3) && q_not_full;
      assign q_data      = {op_r, key_r, val_r, bkt};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r  <= 1'b0;
          phase_r <= '0;
        end else if (in_ch.valid && in_ch.ready) begin
          busy_r  <= 1'b1;
          phase_r <= '0;
        end else if (reducing) begin
          phase_r <= phase_r + 2'd1;
        end else if (q_push) begin
          busy_r <= 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (in_ch.valid && in_ch.ready) begin
          op_r   <= in_ch.op;
          key_r  <= key_in;
          val_r  <= val_in;
          hash_r <= in_ch.hash_value;
        end else if (reducing) begin
          unique case (phase_r)
            2'd0: prod_r <= (HASH_W+33)'(mul_lo);
            2'd1: prod_r <= prod_r + ((HASH_W+33)'(mul_hi) << 17);
            2'd2: diff_r <= hash_r - mul_q[HASH_W-1:0];
            default: begin
            end
          endcase
        end
      end
    end
  endgenerate
endmodule

[design/chm_back.sv]
// ----------------------------------------------------------------------------
// chm_back
// Table engine: walks a bucket chain, edits the entry pool and the free
// list, and holds the result register.
// ----------------------------------------------------------------------------
module chm_back #(
  parameter int BUCKETS    = 256,
  parameter int ENTRIES    = 512,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_not_empty,
  input  logic [chm_pkg::OP_W+KEY_BITS+VALUE_BITS+$clog2(BUCKETS)-1:0] q_data,
  output logic q_pop,
  output logic clear_done,
  chm_out_if.source out_ch
);
  import chm_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int AW = $clog2(ENTRIES);
  localparam int IW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] NONE = IW'(ENTRIES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HEAD, S_HEADW, S_CHK, S_CMP,
    S_MISS, S_FREE, S_INS, S_REM2, S_DONE
  } state_t;

  state_t                state_r;
  logic [OP_W-1:0]       op_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [BW-1:0]         bkt_r;
  logic [BW-1:0]         clr_r;
  logic [IW-1:0]         head_r, cur_r, prev_r, slot_r;
  logic [IW-1:0]         free_head_r, never_used_r, count_r;
  status_t               res_status_r;
  logic [VALUE_BITS-1:0] res_val_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [VALUE_BITS-1:0] out_val_r;
  logic [IW-1:0]         out_occ_r;
  logic                  res_load;

  // RAM ports
  logic                  h_we, k_we, v_we, l_we;
  logic [BW-1:0]         h_wa;
  logic [IW-1:0]         h_wd, h_rd;
  logic [AW-1:0]         v_wa, l_wa, e_ra;
  logic [IW-1:0]         l_wd, link_rd;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic                  hit;

  assign clear_done      = (state_r != S_CLEAR);
  assign q_pop           = (state_r == S_IDLE) && q_not_empty;
  assign hit             = (key_rd == key_r);
  assign res_load        = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign e_ra            = (state_r == S_MISS) ? free_head_r[AW-1:0] : cur_r[AW-1:0];
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.value_out = VALUE_W'(out_val_r);
  assign out_ch.occupancy = OCC_W'(out_occ_r);

  chm_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_heads (
    .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(bkt_r), .rdata(h_rd)
  );
  chm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_keys (
    .clk(clk), .we(k_we), .waddr(slot_r[AW-1:0]), .wdata(key_r), .raddr(e_ra),
    .rdata(key_rd)
  );
  chm_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_values (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(val_r), .raddr(e_ra), .rdata(val_rd)
  );
  chm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_links (
    .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(e_ra), .rdata(link_rd)
  );

  // Write side of the tables.
  always_comb begin
    h_we = 1'b0;
    h_wa = bkt_r;
    h_wd = slot_r;
    k_we = 1'b0;
    v_we = 1'b0;
    v_wa = slot_r[AW-1:0];
    l_we = 1'b0;
    l_wa = slot_r[AW-1:0];
    l_wd = head_r;
    unique case (state_r)
      S_CLEAR: begin
        h_we = 1'b1;
        h_wa = clr_r;
        h_wd = NONE;
      end
      S_CMP: begin
        if (hit && op_r == OP_REMOVE) begin
          if (prev_r == NONE) begin
            h_we = 1'b1;
            h_wd = link_rd;
          end else begin
            l_we = 1'b1;
            l_wa = prev_r[AW-1:0];
            l_wd = link_rd;
          end
        end else if (hit && op_r == OP_INSERT) begin
          v_we = 1'b1;
          v_wa = cur_r[AW-1:0];
        end
      end
      S_REM2: begin
        l_we = 1'b1;
        l_wa = cur_r[AW-1:0];
        l_wd = free_head_r;
      end
      S_INS: begin
        k_we = 1'b1;
        v_we = 1'b1;
        l_we = 1'b1;
        h_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      free_head_r  <= NONE;
      never_used_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + BW'(1);
          if (clr_r == BW'(BUCKETS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_not_empty) begin
            {op_r, key_r, val_r, bkt_r} <= q_data;
            res_val_r <= '0;
            state_r   <= S_HEAD;
          end
        end
        S_HEAD: state_r <= S_HEADW;
        S_HEADW: begin
          head_r  <= h_rd;
          cur_r   <= h_rd;
          prev_r  <= NONE;
          state_r <= S_CHK;
        end
        S_CHK: state_r <= (cur_r == NONE) ? S_MISS : S_CMP;
        S_CMP: begin
          if (hit) begin
            priority case (op_r)
              OP_INSERT: begin
                res_status_r <= ST_UPDATED;
                state_r      <= S_DONE;
              end
              OP_REMOVE: state_r <= S_REM2;
              OP_LOOKUP: begin
                res_status_r <= ST_FOUND;
                res_val_r    <= val_rd;
                state_r      <= S_DONE;
              end
              default: begin
                res_status_r <= ST_NOT_FOUND;
                state_r      <= S_DONE;
              end
            endcase
          end else begin
            prev_r  <= cur_r;
            cur_r   <= link_rd;
            state_r <= S_CHK;
          end
        end
        S_MISS: begin
          if (op_r != OP_INSERT) begin
            res_status_r <= ST_NOT_FOUND;
            state_r      <= S_DONE;
          end else if (free_head_r != NONE) begin
            slot_r  <= free_head_r;
            state_r <= S_FREE;
          end else if (never_used_r != NONE) begin
            slot_r       <= never_used_r;
            never_used_r <= never_used_r + IW'(1);
            state_r      <= S_INS;
          end else begin
            res_status_r <= ST_FULL;
            state_r      <= S_DONE;
          end
        end
        S_FREE: begin
          free_head_r <= link_rd;
          state_r     <= S_INS;
        end
        S_INS: begin
          count_r      <= count_r + IW'(1);
          res_status_r <= ST_INSERTED;
          state_r      <= S_DONE;
        end
        S_REM2: begin
          free_head_r <= cur_r;
          if (count_r != '0) begin
            count_r <= count_r - IW'(1);
          end
          res_status_r <= ST_REMOVED;
          state_r      <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            out_status_r <= res_status_r;
            out_val_r    <= res_val_r;
            out_occ_r    <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[design/chained_hash_map.sv]
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-value map built as a separately chained hash table over a fixed pool.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Transaction
//  in_ch    sink       op, key, value, hash_value
//  out_ch   source     status, value_out, occupancy
//
//  After reset the bucket-head table is swept once, one bucket a cycle, and
//  the block takes no request until the sweep is over.
//  When BUCKETS is a power of two the front end passes a request straight
//  into the queue; otherwise it finds the bucket by a reciprocal
//  multiplication in two halves, taking no new request until it is queued.
//  The table engine reads the chain head, visits the chain entries one by
//  one, makes any edit and hands over the result; the single read port of
//  the entry RAMs sets the walk rate.
//  A queue of two requests and the result register let either side stall.
//
module chained_hash_map #(
  parameter int BUCKETS    = 256,
  parameter int ENTRIES    = 512,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic clk,
  input  logic rst_n,
  chm_in_if.sink    in_ch,
  chm_out_if.source out_ch
);
  import chm_pkg::*;

  // A queued request carries the operation, the masked key and value, and
  // the bucket index.
  localparam int QW = OP_W + KEY_BITS + VALUE_BITS + $clog2(BUCKETS);

  logic          clear_done;
  logic          q_push, q_pop, q_not_full, q_not_empty;
  logic [QW-1:0] q_in, q_out;

  // The front end is held off until the bucket sweep after reset is over.
  chm_front #(
    .BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .enable(clear_done), .in_ch(in_ch),
    .q_not_full(q_not_full), .q_push(q_push), .q_data(q_in)
  );

  chm_queue #(.WIDTH(QW)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in),
    .not_full(q_not_full), .pop(q_pop), .not_empty(q_not_empty),
    .pop_data(q_out)
  );

  // The table engine owns all table RAMs, the free list and the counters.
  chm_back #(
    .BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_not_empty(q_not_empty), .q_data(q_out),
    .q_pop(q_pop), .clear_done(clear_done), .out_ch(out_ch)
  );

  // No request gets in while the bucket heads are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clear_done |-> !in_ch.ready)
    else $error("request accepted during bucket sweep");

  // Only a found lookup returns a value.
  a_value_only_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != ST_FOUND |-> out_ch.value_out == '0)
    else $error("value returned without a hit");

  // The occupancy never exceeds the pool.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.occupancy <= OCC_W'(ENTRIES))
    else $error("occupancy beyond pool size");

  // The queue is never written when full.
  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> q_not_full)
    else $error("push into full queue");
endmodule

[bench/tb_chained_hash_map.sv]
// ----------------------------------------------------------------------------
// tb_chained_hash_map
// Self-checking bench for the chained hash map. A behavioral copy of the table
// predicts status, returned value and occupancy for every request; results are
// checked in order against those predictions under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_chained_hash_map;
  timeunit 1ns;
  timeprecision 1ps;

  import chm_pkg::*;

  localparam int N_BUCKETS = 256;
  localparam int N_SLOTS   = 512;
  localparam int NO_LINK   = N_SLOTS;
  localparam int MAX_CYCLES = 10_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  chm_in_if  in_ch ();
  chm_out_if out_ch ();

  chained_hash_map #(
    .BUCKETS(N_BUCKETS), .ENTRIES(N_SLOTS), .KEY_BITS(32), .VALUE_BITS(32)
  ) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // One predicted result of the table.
  typedef struct packed {
    status_t              status;
    logic [VALUE_W-1:0]   value_out;
    logic [OCC_W-1:0]     occupancy;
  } map_result_t;

  // Shadow copy of the table state.
  int unsigned       head_of[N_BUCKETS];
  logic [KEY_W-1:0]  slot_key[N_SLOTS];
  logic [VALUE_W-1:0] slot_val[N_SLOTS];
  int unsigned       slot_next[N_SLOTS];
  int unsigned       free_head;
  int unsigned       fresh_count;
  int unsigned       live_count;

  map_result_t pending_results[$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          long_hold = 1'b0;  // Forces the result side to stall.
  bit          sink_random = 1'b1;
  bit          got_result = 1'b0; // Set at each accepted result.

  // Keys once sent in an insert, with the hash they were sent under, so that
  // the random part can hit them again.
  logic [KEY_W-1:0]  known_keys[$];
  logic [HASH_W-1:0] known_hashes[$];

  // Computes the result of one request and applies it to the shadow table.
  function automatic map_result_t apply_request(logic [OP_W-1:0] op,
                                                logic [KEY_W-1:0] key,
                                                logic [VALUE_W-1:0] val,
                                                logic [HASH_W-1:0] hash);
    int unsigned bkt, cur, prv, hit, nxt, slot, steps;
    map_result_t r;
    bkt = hash % N_BUCKETS;
    cur = head_of[bkt];
    prv = NO_LINK;
    hit = NO_LINK;
    steps = 0;
    while (steps < N_SLOTS && cur < N_SLOTS) begin
      if (slot_key[cur] == key) begin
        hit = cur;
        break;
      end
      prv = cur;
      cur = slot_next[cur];
      steps++;
    end
    if (hit == NO_LINK) prv = NO_LINK;
    r.status = ST_NOT_FOUND;
    r.value_out = '0;
    if (op == OP_INSERT) begin
      if (hit < N_SLOTS) begin
        slot_val[hit] = val;
        r.status = ST_UPDATED;
      end else begin
        slot = NO_LINK;
        if (free_head < N_SLOTS) begin
          slot = free_head;
          free_head = slot_next[slot];
        end else if (fresh_count < N_SLOTS) begin
          slot = fresh_count;
          fresh_count++;
        end
        if (slot < N_SLOTS) begin
          slot_key[slot] = key;
          slot_val[slot] = val;
          slot_next[slot] = head_of[bkt];
          head_of[bkt] = slot;
          live_count++;
          r.status = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end
    end else if (op == OP_REMOVE) begin
      if (hit < N_SLOTS) begin
        nxt = slot_next[hit];
        if (prv < N_SLOTS) slot_next[prv] = nxt;
        else head_of[bkt] = nxt;
        slot_next[hit] = free_head;
        free_head = hit;
        if (live_count > 0) live_count--;
        r.status = ST_REMOVED;
      end
    end else if (op == OP_LOOKUP) begin
      if (hit < N_SLOTS) begin
        r.value_out = slot_val[hit];
        r.status = ST_FOUND;
      end
    end
    r.occupancy = live_count[OCC_W-1:0];
    return r;
  endfunction

  // Sends one request: waits a random gap, offers it until accepted, and
  // records the predicted result at the accepting edge. Valid stays high
  // when the next request follows without a gap.
  task automatic send_request(logic [OP_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [VALUE_W-1:0] val, logic [HASH_W-1:0] hash,
                              bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.key <= key;
    in_ch.value <= val;
    in_ch.hash_value <= hash;
    do @(posedge clk); while (!(in_ch.ready === 1'b1));
    pending_results.push_back(apply_request(op, key, val, hash));
    if (op == OP_INSERT) begin
      known_keys.push_back(key);
      known_hashes.push_back(hash);
    end
    @(negedge clk);
  endtask

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)",
             what, got, want, cycle_count);
  endtask

  // The result side: a random stall drawn for every transaction, or a long
  // hold when the pressure test asks for it.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (got_result || out_ch.ready !== 1'b1) begin
        got_result = 1'b0;
        stall = sink_random ? $urandom_range(0, 17) : 0;
        if ($urandom_range(0, 3) == 0) stall = 0;
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        if (!long_hold) out_ch.ready <= 1'b1;
      end
    end
  end

  // Checks every accepted result against the oldest prediction.
  always @(posedge clk) begin
    map_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got_result = 1'b1;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_ch.status, -1);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.value_out !== want.value_out)
          report_mismatch("value_out", out_ch.value_out, want.value_out);
        if (out_ch.occupancy !== want.occupancy)
          report_mismatch("occupancy", out_ch.occupancy, want.occupancy);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Picks a key, mostly from those sent in an insert before, with its hash.
  task automatic pick_key(output logic [KEY_W-1:0] key,
                          output logic [HASH_W-1:0] hash);
    int idx;
    if (known_keys.size() > 0 && $urandom_range(0, 3) != 0) begin
      idx = $urandom_range(0, known_keys.size() - 1);
      key = known_keys[idx];
      hash = known_hashes[idx];
      // Now and then the same key arrives under another bucket.
      if ($urandom_range(0, 15) == 0) hash = $urandom();
    end else begin
      key = $urandom_range(0, 63);
      if ($urandom_range(0, 3) == 0) key = $urandom();
      // Few buckets in use give long chains.
      hash = $urandom_range(0, 1) ? {24'($urandom()), 8'($urandom_range(0, 3))}
                                  : $urandom();
    end
  endtask

  // Extremes of every field, each operation, the unused op code, removal in
  // the middle of a chain and lookups of absent keys.
  task automatic test_directed();
    send_request(OP_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FF00);
    send_request(OP_INSERT, 32'h1234_5678, 32'hA5A5_A5A5, 32'h0000_0100);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'hFFFF_FF00);
    send_request(OP_INSERT, 32'h0, 32'h5A5A_5A5A, 32'h0);
    send_request(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF, 32'h0);
    send_request(2'd3, 32'h0, 32'h1, 32'h0);
    send_request(OP_REMOVE, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0);
    send_request(OP_INSERT, 32'h0000_0007, 32'h7, 32'h0);
    send_request(OP_REMOVE, 32'h0, 32'h0, 32'h0);
    send_request(OP_LOOKUP, 32'h1234_5678, 32'h0, 32'h0);
    send_request(OP_LOOKUP, 32'h0000_0007, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF);
    send_request(OP_LOOKUP, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
  endtask

  // Fills the pool to the brim, shows the full report and an update in a full
  // pool, then empties part of it through the free list. Each fill key is
  // stored in the bucket given by its low four bits.
  task automatic test_fill_pool();
    logic [KEY_W-1:0] k;
    while (live_count < N_SLOTS) begin
      k = 32'h4000_0000 + live_count;
      send_request(OP_INSERT, k, $urandom(), {28'h0, k[3:0]}, 1'b1);
    end
    send_request(OP_INSERT, 32'h7777_7777, 32'h1, 32'h3);
    send_request(OP_INSERT, 32'h4000_01FF, 32'hDEAD_BEEF, 32'hF);
    send_request(OP_LOOKUP, 32'h4000_01FF, 32'h0, 32'hF);
    for (int i = 0; i < N_SLOTS; i += 2) begin
      k = 32'h4000_0000 + i;
      send_request(OP_REMOVE, k, $urandom(), {28'h0, k[3:0]}, 1'b1);
    end
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the block fills up and stops taking new ones.
  task automatic test_backpressure();
    logic [KEY_W-1:0] k;
    logic [HASH_W-1:0] h;
    fork
      begin
        long_hold = 1'b1;
        repeat (400) @(negedge clk);
        long_hold = 1'b0;
      end
      repeat (12) begin
        pick_key(k, h);
        send_request(2'($urandom_range(0, 2)), k, $urandom(), h, 1'b1);
      end
    join
  endtask

  // Random mix weighted toward inserts and hits on stored keys; a stretch
  // without idling on either side sits in the middle.
  task automatic test_random_mix();
    logic [KEY_W-1:0] k;
    logic [HASH_W-1:0] h;
    logic [OP_W-1:0] op;
    int r;
    for (int i = 0; i < 100; i++) begin
      sink_random = !(i >= 40 && i < 60);
      pick_key(k, h);
      r = $urandom_range(0, 19);
      if (r < 8) op = OP_INSERT;
      else if (r < 13) op = OP_REMOVE;
      else if (r < 19) op = OP_LOOKUP;
      else op = 2'd3;
      send_request(op, k, $urandom(), h, !sink_random);
    end
    sink_random = 1'b1;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOOKUP;
    in_ch.key = '0;
    in_ch.value = '0;
    in_ch.hash_value = '0;
    for (int i = 0; i < N_BUCKETS; i++) head_of[i] = NO_LINK;
    for (int i = 0; i < N_SLOTS; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
      slot_next[i] = NO_LINK;
    end
    free_head = NO_LINK;
    fresh_count = 0;
    live_count = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_fill_pool();
    test_random_mix();
    in_ch.valid <= 1'b0;

    // Drain, then allow for the block's last hand-over.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
